// File: rtl/dlts_pkg.sv
// Package for the delta-list task scheduler.
// Holds the command and status codes, the channel payload structs and the queue entry layout.
// No dependencies.
package dlts_pkg;

  localparam logic [1:0] CMD_ADD      = 2'd0;
  localparam logic [1:0] CMD_TICK     = 2'd1;
  localparam logic [1:0] CMD_DISPATCH = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN  = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  // Width of the millisecond fields and of the tick counts stored in the queue.
  localparam int MS_W = 32;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [7:0]      task_id;
    logic [MS_W-1:0] delay_ms;
    logic [MS_W-1:0] period_ms;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       ran;
    logic [7:0] run_task_id;
    logic [4:0] queue_count;
  } out_t;

  typedef struct packed {
    logic [7:0]      id;
    logic [MS_W-1:0] delay;
    logic [MS_W-1:0] period;
    logic [7:0]      runs;
  } entry_t;

endpackage

// File: rtl/dlts_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module dlts_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// File: rtl/delta_list_task_scheduler.sv
// Delta-list task scheduler, top level.
// Depends on dlts_pkg (types, codes) and dlts_ram (queue entry storage).
//
//  Channel | Ports                          | Payload
//  --------+--------------------------------+---------------------------------------
//  input   | in_valid, in_stall, in_data    | cmd, task_id, delay_ms, period_ms
//  result  | out_valid, out_stall, out_data | status, ran, run_task_id, queue_count
//
// One transaction is worked on at a time; each input transaction yields exactly one result.
// An add passes through the reciprocal divider and then walks the queue, shifts the entries
// behind its place and writes; a tick reads and rewrites the head, and a dispatch removes the
// head and walks a periodic task back in. The entry RAM's single read port puts a read state
// before each check or write; the block returns to idle before accepting the next transaction.
// Reset (synchronous, rst_n low) empties the queue; no clearing pass is needed because only
// entries below the task count are ever read.
// A stalled result holds in the output register while the next transaction is accepted; that
// transaction finishes only once the register is free.
module delta_list_task_scheduler
  import dlts_pkg::*;
#(
  parameter int MAX_TASKS = 16,
  parameter int TICK_MS   = 10
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Address width of the queue RAM, width of logical positions and counts (0..MAX_TASKS),
  // width of running sums of delays, and half the width of a millisecond field.
  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int SW = MS_W + CW;
  localparam int HW = MS_W / 2;
  localparam int EW = $bits(entry_t);
  // floor(2^MS_W / TICK_MS); the product with a field gives the quotient or one less.
  localparam logic [MS_W:0] RECIP = (MS_W+1)'((65'd1 << MS_W) / TICK_MS);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_HEAD_RD, S_HEAD_UPD, S_WALK_RD, S_WALK_CHK,
    S_SH_RD, S_SH_WR, S_PUT_NEXT, S_PUT_NEW, S_DONE
  } state_t;

  state_t            state_r;
  logic [1:0]        cmd_r;
  logic [7:0]        nid_r;
  logic [MS_W-1:0]   nd_r;
  logic [MS_W-1:0]   np_r;
  logic [7:0]        nr_r;
  logic [2*MS_W-1:0] accd_r;
  logic [2*MS_W-1:0] accp_r;
  logic [MS_W-1:0]   remd_r;
  logic [MS_W-1:0]   remp_r;
  logic [1:0]        div_cnt_r;
  logic [CW-1:0]     pos_r;
  logic [CW-1:0]     sh_r;
  logic [SW-1:0]     before_r;
  entry_t            save_r;
  logic [AW-1:0]     head_r;
  logic [CW-1:0]     count_r;
  logic [1:0]        status_r;
  logic              ran_r;
  logic [7:0]        rid_r;
  out_t              out_r;
  logic              out_valid_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic [EW-1:0]     ram_rbits;

  entry_t            tick_entry;
  logic [SW-1:0]     walk_at;
  logic              walk_past;
  logic [CW+4:0]     count_ext;
  logic [HW+MS_W:0]  mul_d;
  logic [HW+MS_W:0]  mul_p;
  logic [MS_W-1:0]   qd_est;
  logic [MS_W-1:0]   qp_est;
  logic              out_load;

  // Maps a position in the queue to a RAM address; the queue is circular around head_r.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] l);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(l);
    if (s >= (CW+1)'(MAX_TASKS)) begin
      s = s - (CW+1)'(MAX_TASKS);
    end
    return s[AW-1:0];
  endfunction

  // Partial product of one half of a millisecond field with the reciprocal.
  function automatic logic [HW+MS_W:0] mul_recip(input logic [HW-1:0] a);
    return (HW+MS_W+1)'(a) * (HW+MS_W+1)'(RECIP);
  endfunction

  dlts_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_TASKS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rbits)
  );

  assign ram_rdata = entry_t'(ram_rbits);

  // The divider multiplies the low half of each field in its first step and the high half
  // in its second, then takes the estimate and corrects it by one where the remainder allows.
  assign mul_d  = mul_recip((div_cnt_r == 2'd0) ? nd_r[HW-1:0] : nd_r[MS_W-1:HW]);
  assign mul_p  = mul_recip((div_cnt_r == 2'd0) ? np_r[HW-1:0] : np_r[MS_W-1:HW]);
  assign qd_est = accd_r[2*MS_W-1:MS_W];
  assign qp_est = accp_r[2*MS_W-1:MS_W];

  // A tick on a due head bumps its run count (saturating) and reloads a nonzero period;
  // otherwise it counts the head's delay down.
  always_comb begin
    tick_entry = ram_rdata;
    if (ram_rdata.delay == '0) begin
      if (ram_rdata.runs != 8'hFF) begin
        tick_entry.runs = ram_rdata.runs + 8'd1;
      end
      if (ram_rdata.period != '0) begin
        tick_entry.delay = ram_rdata.period;
      end
    end else begin
      tick_entry.delay = ram_rdata.delay - 1'b1;
    end
  end

  // Walking the list: the absolute due time of the entry just read, and whether the new task
  // belongs behind it. Equal due times put the new task in front.
  assign walk_at   = before_r + SW'(ram_rdata.delay);
  assign walk_past = SW'(nd_r) > walk_at;

  always_comb begin
    ram_raddr = head_r;
    ram_we    = 1'b0;
    ram_waddr = head_r;
    ram_wdata = ram_rdata;
    unique case (state_r)
      S_WALK_RD: ram_raddr = phys(head_r, pos_r);
      S_SH_RD:   ram_raddr = phys(head_r, sh_r - 1'b1);
      S_HEAD_UPD: begin
        if (cmd_r == CMD_TICK) begin
          ram_we    = 1'b1;
          ram_wdata = tick_entry;
        end
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, sh_r);
      end
      S_PUT_NEXT: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, pos_r + 1'b1);
        ram_wdata = save_r;
      end
      S_PUT_NEW: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, pos_r);
        ram_wdata = '{id: nid_r, delay: nd_r - before_r[MS_W-1:0], period: np_r, runs: nr_r};
      end
      default: begin
      end
    endcase
  end

  assign count_ext = (CW+5)'(count_r);

  // The result register loads when a finished transaction finds it empty or draining.
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r     <= in_data.cmd;
            nid_r     <= in_data.task_id;
            nd_r      <= in_data.delay_ms;
            np_r      <= in_data.period_ms;
            nr_r      <= '0;
            div_cnt_r <= '0;
            status_r  <= ST_NONE;
            ran_r     <= 1'b0;
            rid_r     <= '0;
            case (in_data.cmd) inside
              CMD_ADD: begin
                if (count_r == CW'(MAX_TASKS)) begin
                  status_r <= ST_FULL;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_DIV;
                end
              end
              CMD_TICK, CMD_DISPATCH: begin
                state_r <= (count_r == '0) ? S_DONE : S_HEAD_RD;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          case (div_cnt_r)
            2'd0: begin
              accd_r <= (2*MS_W)'(mul_d);
              accp_r <= (2*MS_W)'(mul_p);
            end
            2'd1: begin
              accd_r <= accd_r + {mul_d[2*MS_W-HW-1:0], HW'(0)};
              accp_r <= accp_r + {mul_p[2*MS_W-HW-1:0], HW'(0)};
            end
            2'd2: begin
              nd_r   <= qd_est;
              np_r   <= qp_est;
              remd_r <= nd_r - qd_est * MS_W'(TICK_MS);
              remp_r <= np_r - qp_est * MS_W'(TICK_MS);
            end
            default: begin
              if (remd_r >= MS_W'(TICK_MS)) begin
                nd_r <= nd_r + 1'b1;
              end
              if (remp_r >= MS_W'(TICK_MS)) begin
                np_r <= np_r + 1'b1;
              end
              pos_r    <= '0;
              before_r <= '0;
              state_r  <= S_WALK_RD;
            end
          endcase
        end
        S_HEAD_RD: state_r <= S_HEAD_UPD;
        S_HEAD_UPD: begin
          if (cmd_r == CMD_TICK) begin
            status_r <= ST_DONE;
            state_r  <= S_DONE;
          end else if (ram_rdata.runs == '0) begin
            state_r <= S_DONE;
          end else begin
            // Dispatch: the head leaves by moving the head pointer; a periodic task goes
            // back in with its current delay as an absolute due time.
            status_r <= ST_DONE;
            ran_r    <= 1'b1;
            rid_r    <= ram_rdata.id;
            head_r   <= phys(head_r, CW'(1));
            count_r  <= count_r - 1'b1;
            nid_r    <= ram_rdata.id;
            nd_r     <= ram_rdata.delay;
            np_r     <= ram_rdata.period;
            nr_r     <= ram_rdata.runs - 8'd1;
            pos_r    <= '0;
            before_r <= '0;
            state_r  <= (ram_rdata.period != '0) ? S_WALK_RD : S_DONE;
          end
        end
        S_WALK_RD: begin
          state_r <= (pos_r == count_r) ? S_PUT_NEW : S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (walk_past) begin
            before_r <= walk_at;
            pos_r    <= pos_r + 1'b1;
            state_r  <= S_WALK_RD;
          end else begin
            save_r  <= '{id: ram_rdata.id, delay: MS_W'(walk_at - SW'(nd_r)),
                         period: ram_rdata.period, runs: ram_rdata.runs};
            sh_r    <= count_r;
            state_r <= ((CW+1)'(count_r) > (CW+1)'(pos_r) + 1'b1) ? S_SH_RD : S_PUT_NEXT;
          end
        end
        S_SH_RD: state_r <= S_SH_WR;
        S_SH_WR: begin
          sh_r    <= sh_r - 1'b1;
          state_r <= ((CW+1)'(sh_r) > (CW+1)'(pos_r) + (CW+1)'(2)) ? S_SH_RD : S_PUT_NEXT;
        end
        S_PUT_NEXT: state_r <= S_PUT_NEW;
        S_PUT_NEW: begin
          count_r  <= count_r + 1'b1;
          status_r <= ST_DONE;
          state_r  <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_r.status      <= status_r;
            out_r.ran         <= ran_r;
            out_r.run_task_id <= rid_r;
            out_r.queue_count <= count_ext[4:0];
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The queue never holds more tasks than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_TASKS))
    else $error("task count above queue depth");

  // A served dispatch always reports done.
  a_ran_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.ran || out_r.status == ST_DONE))
    else $error("ran set with a status other than done");

  // An accepted transaction keeps the input side stalled in the following cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is in progress");

endmodule

// File: test/delta_list_task_scheduler_tb.sv
// Self-checking testbench for the delta-list task scheduler.
// Depends on dlts_pkg and delta_list_task_scheduler.
// It predicts every result from its own model of the queue and compares the results field by field.
`timescale 1ns / 100ps

module delta_list_task_scheduler_tb;
  import dlts_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int TICK_LEN    = 10;
  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  delta_list_task_scheduler #(.MAX_TASKS(QUEUE_DEPTH), .TICK_MS(TICK_LEN)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the timer queue. Delays are in ticks and relative to the entry ahead.
  bit [7:0]  sh_id     [QUEUE_DEPTH];
  bit [31:0] sh_delay  [QUEUE_DEPTH];
  bit [31:0] sh_period [QUEUE_DEPTH];
  bit [7:0]  sh_runs   [QUEUE_DEPTH];
  int        sh_len = 0;

  in_t  cmd_backlog[$];     // commands still to be offered to the block
  out_t expected_replies[$]; // predicted replies, oldest first
  int   error_count = 0;
  int   sent_count = 0;
  int   reply_count = 0;
  int   dispatched_count = 0;
  int   full_count = 0;
  bit   hold_done = 1'b0;

  // Insert a task by absolute due time; it goes ahead of any entry with an equal due time.
  function automatic void place_task(bit [7:0] id, bit [31:0] due, bit [31:0] per,
                                     bit [7:0] runs);
    int pos;
    longint unsigned ahead;
    longint unsigned here;
    pos = 0;
    ahead = 0;
    if (sh_len == 0) begin
      sh_id[0] = id; sh_delay[0] = due; sh_period[0] = per; sh_runs[0] = runs;
      sh_len = 1;
      return;
    end
    here = sh_delay[0];
    while (pos < sh_len && longint'(due) > here) begin
      pos++;
      if (pos < sh_len) begin
        ahead = here;
        here += sh_delay[pos];
      end
    end
    if (pos == sh_len) begin
      sh_id[pos] = id; sh_delay[pos] = 32'(longint'(due) - here);
      sh_period[pos] = per; sh_runs[pos] = runs;
    end else begin
      for (int i = sh_len; i > pos; i--) begin
        sh_id[i] = sh_id[i-1]; sh_delay[i] = sh_delay[i-1];
        sh_period[i] = sh_period[i-1]; sh_runs[i] = sh_runs[i-1];
      end
      sh_id[pos] = id; sh_delay[pos] = 32'(longint'(due) - ahead);
      sh_period[pos] = per; sh_runs[pos] = runs;
      // The entry pushed back now counts from the new task.
      sh_delay[pos+1] = 32'(here - longint'(due));
    end
    sh_len++;
  endfunction

  // Apply one command to the shadow queue and return the reply the block must give.
  function automatic out_t schedule_reply(in_t c);
    out_t r;
    bit [7:0]  hid;
    bit [31:0] hd;
    bit [31:0] hp;
    bit [7:0]  hr;
    r = '0;
    r.status = ST_NONE;
    case (c.cmd)
      CMD_ADD: begin
        if (sh_len >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          place_task(c.task_id, c.delay_ms / TICK_LEN, c.period_ms / TICK_LEN, 8'd0);
          r.status = ST_DONE;
        end
      end
      CMD_TICK: begin
        if (sh_len > 0) begin
          if (sh_delay[0] == 0) begin
            if (sh_runs[0] != 8'hFF) sh_runs[0]++;
            if (sh_period[0] != 0) sh_delay[0] = sh_period[0];
          end else begin
            sh_delay[0]--;
          end
          r.status = ST_DONE;
        end
      end
      CMD_DISPATCH: begin
        if (sh_len > 0 && sh_runs[0] != 0) begin
          hid = sh_id[0]; hd = sh_delay[0]; hp = sh_period[0]; hr = sh_runs[0] - 8'd1;
          for (int i = 0; i + 1 < sh_len; i++) begin
            sh_id[i] = sh_id[i+1]; sh_delay[i] = sh_delay[i+1];
            sh_period[i] = sh_period[i+1]; sh_runs[i] = sh_runs[i+1];
          end
          sh_len--;
          if (hp != 0) place_task(hid, hd, hp, hr);
          r.status = ST_DONE;
          r.ran = 1'b1;
          r.run_task_id = hid;
        end
      end
      default: ;
    endcase
    r.queue_count = 5'(sh_len);
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    error_count++;
    $display("%0t: reply %0d field %s is %0d, predicted %0d", $realtime, reply_count,
             field, got, want);
  endtask

  function automatic in_t make_cmd(bit [1:0] op, bit [7:0] id, bit [31:0] d, bit [31:0] p);
    in_t c;
    c.cmd = op; c.task_id = id; c.delay_ms = d; c.period_ms = p;
    return c;
  endfunction

  // Mostly short delays so that tasks come due within a few ticks; now and then any value.
  function automatic bit [31:0] pick_ms(bit periodic);
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom();
    if (sel == 1) return 32'hFFFF_FFFF;
    if (periodic && sel < 9) return 32'd0;
    return $urandom_range(0, 60);
  endfunction

  // Sender: one command per transaction, with a random gap before each, except in stretches
  // where the gap is always zero.
  int send_gap = 0;
  always @(posedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(schedule_reply(in_data));
        sent_count++;
        next_valid = 1'b0;
      end
      if (!next_valid && cmd_backlog.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          in_data <= cmd_backlog.pop_front();
          next_valid = 1'b1;
          send_gap = ((sent_count / 150) % 3 == 2) ? 0 : $urandom_range(0, 3);
        end
      end
    end
    in_valid <= next_valid;
  end

  // Receiver: checks each reply transaction and stalls for a random draw after each reply, and
  // also while the long hold below is running.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          error_count++;
          $display("%0t: reply with no command waiting for it", $realtime);
        end else begin
          want = expected_replies.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.ran !== want.ran)
            report_mismatch("ran", out_data.ran, want.ran);
          if (out_data.run_task_id !== want.run_task_id)
            report_mismatch("run_task_id", out_data.run_task_id, want.run_task_id);
          if (out_data.queue_count !== want.queue_count)
            report_mismatch("queue_count", out_data.queue_count, want.queue_count);
          if (want.ran) dispatched_count++;
          if (want.status == ST_FULL) full_count++;
        end
        reply_count++;
        stall_left = ((reply_count / 200) % 3 == 1) ? 0 : $urandom_range(0, 3);
      end else if (hold_left == 0 && stall_left > 0) begin
        stall_left--;
      end
    end
    out_stall <= (hold_left > 0) || (stall_left > 0);
  end

  // Once, after a few hundred replies, the receiver holds off for a long stretch so the
  // block fills up and has to stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && reply_count >= 300) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Watchdog: any long stretch with no transaction on either channel ends the run.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (cmd_backlog.size() > 0 || in_valid || expected_replies.size() > 0) begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int kind;
    int burst;
    int roll;
    // Directed part: empty-queue commands, the unknown command, field extremes, equal due
    // times, a zero-delay task, a periodic task that is reinserted, and then a few ticks.
    cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 8'd0, 32'd0, 32'd0));
    cmd_backlog.push_back(make_cmd(CMD_TICK, 8'd0, 32'd0, 32'd0));
    cmd_backlog.push_back(make_cmd(CMD_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 8'd0, 32'd0, 32'd0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 8'd7, 32'd9, 32'd0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 8'd8, 32'd25, 32'd20));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 8'd9, 32'd29, 32'd0));
    cmd_backlog.push_back(make_cmd(CMD_ADD, 8'd10, 32'hFFFF_FFF0, 32'd10));
    cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 8'd0, 32'd0, 32'd0));
    cmd_backlog.push_back(make_cmd(CMD_TICK, 8'd0, 32'd0, 32'd0));
    cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 8'd0, 32'd0, 32'd0));
    cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 8'd0, 32'd0, 32'd0));
    for (int i = 0; i < 6; i++) cmd_backlog.push_back(make_cmd(CMD_TICK, 8'd0, 32'd0, 32'd0));
    for (int i = 0; i < 4; i++)
      cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 8'd0, 32'd0, 32'd0));

    // Random part in bursts: fills that drive the queue full, steady mixes of adds, ticks and
    // dispatches, and long tick runs that push a due task's run count to saturation.
    while (cmd_backlog.size() < 1720) begin
      kind = $urandom_range(0, 9);
      burst = $urandom_range(10, 40);
      if (kind == 0) burst = 280;
      for (int i = 0; i < burst && cmd_backlog.size() < 1720; i++) begin
        roll = $urandom_range(0, 99);
        if (kind == 0) begin
          roll = (i == 0) ? 0 : 50;
        end else if (kind < 3) begin
          roll = (roll < 90) ? 0 : roll;
        end
        if (roll < 30) begin
          cmd_backlog.push_back(make_cmd(CMD_ADD, 8'($urandom()), pick_ms(1'b0),
                                         pick_ms(1'b1)));
        end else if (roll < 65) begin
          cmd_backlog.push_back(make_cmd(CMD_TICK, 8'($urandom()), $urandom(), $urandom()));
        end else if (roll < 97) begin
          cmd_backlog.push_back(make_cmd(CMD_DISPATCH, 8'($urandom()), $urandom(),
                                         $urandom()));
        end else begin
          cmd_backlog.push_back(make_cmd(CMD_UNKNOWN, 8'($urandom()), $urandom(),
                                         $urandom()));
        end
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Sent %0d commands; %0d dispatches ran, %0d adds found the queue full.",
             sent_count, dispatched_count, full_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
